[sv/inode_cache_clock_replacement_assert.svh]
// Assertion macros for the inode cache clock replacement block.
// Used by the back end and the top level; no dependencies.
`ifndef INODE_CACHE_CLOCK_REPLACEMENT_ASSERT_SVH
`define INODE_CACHE_CLOCK_REPLACEMENT_ASSERT_SVH

// Implication checked at every edge outside reset.
`define ICCR_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define ICCR_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");

`endif

[sv/iccr_pkg.sv]
// Shared types and constants for the inode cache clock replacement block.
// No dependencies.
package iccr_pkg;
  localparam int CacheEntriesDef = 16;
  localparam int TagW = 32;
  localparam int SlotW = 4;
  localparam int IpbW = 9;
  localparam logic [IpbW-1:0] IpbReset = 9'd8;

  typedef enum logic [1:0] {
    OP_GET = 2'd0,
    OP_INSERT = 2'd1,
    OP_DIRTY = 2'd2,
    OP_NOP = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [TagW-1:0] ino_num;
    logic [SlotW-1:0] slot;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic [SlotW-1:0] slot_out;
    logic fill_needed;
    logic writeback_valid;
    logic [TagW-1:0] writeback_inode;
    logic [TagW-1:0] writeback_block;
    logic [7:0] writeback_offset;
  } res_t;
endpackage

[sv/iccr_front.sv]
// Front end: accepts command words and holds them in a two-entry queue.
// Depends on iccr_pkg.
module iccr_front (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  iccr_pkg::cmd_t in_cmd,
  output logic q_valid,
  input  logic q_ready,
  output iccr_pkg::cmd_t q_cmd
);
  iccr_pkg::cmd_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd = mem_r[rp_r];
  assign push = in_valid && in_ready;
  assign pop = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_cmd;
    end
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

[sv/iccr_div.sv]
// Restoring divider, one quotient bit a cycle, for the writeback location.
// Depends on iccr_pkg.
module iccr_div (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic [iccr_pkg::TagW-1:0] dividend,
  input  logic [iccr_pkg::IpbW-1:0] divisor,
  output logic busy,
  output logic [iccr_pkg::TagW-1:0] quot,
  output logic [iccr_pkg::IpbW-1:0] rem
);
  localparam int W = iccr_pkg::TagW;
  localparam int D = iccr_pkg::IpbW;
  logic [W-1:0] q_r;
  logic [D:0] r_r;
  logic [D-1:0] d_r;
  logic [5:0] n_r;
  logic [D:0] sh, df;

  assign sh = {r_r[D-1:0], q_r[W-1]};
  assign df = sh - {1'b0, d_r};
  assign busy = (n_r != 6'd0);
  assign quot = q_r;
  assign rem = r_r[D-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= 6'd0;
    end else if (start) begin
      q_r <= dividend;
      r_r <= '0;
      d_r <= (divisor == '0) ? D'(1) : divisor;
      n_r <= 6'(W);
    end else if (busy) begin
      n_r <= n_r - 6'd1;
      if (!df[D]) begin
        r_r <= df;
        q_r <= {q_r[W-2:0], 1'b1};
      end else begin
        r_r <= sh;
        q_r <= {q_r[W-2:0], 1'b0};
      end
    end
  end
endmodule

[sv/iccr_back.sv]
// Back end: tag search, clock sweep, state update and result register.
// Depends on iccr_pkg, iccr_div and the assertion macro header.
`include "inode_cache_clock_replacement_assert.svh"
module iccr_back #(
  parameter int CACHE_ENTRIES = iccr_pkg::CacheEntriesDef
) (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  output logic q_ready,
  input  iccr_pkg::cmd_t q_cmd,
  input  logic [iccr_pkg::IpbW-1:0] ipb,
  output logic res_valid,
  input  logic res_ready,
  output iccr_pkg::res_t res
);
  localparam int IW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int CW = $clog2(CACHE_ENTRIES + 1);
  localparam int RestW = $bits(iccr_pkg::res_t) - 1 - iccr_pkg::SlotW;

  typedef enum logic [2:0] {S_IDLE, S_SEARCH, S_SWEEP, S_INSTALL, S_DIV, S_OUT} st_t;
  st_t st_r;
  iccr_pkg::cmd_t cmd_r;
  iccr_pkg::res_t res_r;
  logic [CACHE_ENTRIES-1:0] val_r, ref_r, dty_r;
  logic [iccr_pkg::TagW-1:0] tag_r [CACHE_ENTRIES];
  logic [IW-1:0] hand_r, idx_r, vic_r;
  logic [CW-1:0] cnt_r;
  logic div_start;
  logic div_busy;
  logic [iccr_pkg::TagW-1:0] div_q;
  logic [iccr_pkg::IpbW-1:0] div_rm;
  logic [IW-1:0] hand_inc, idx_inc;
  logic dirty_ok;

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] h);
    return (32'(h) == CACHE_ENTRIES - 1) ? '0 : h + IW'(1);
  endfunction

  assign hand_inc = wrap_inc(hand_r);
  assign idx_inc = idx_r + IW'(1);
  assign q_ready = (st_r == S_IDLE) && !res_valid;
  assign res_valid = (st_r == S_OUT);
  assign res = res_r;
  assign div_start = (st_r == S_INSTALL) && val_r[vic_r] && dty_r[vic_r];
  assign dirty_ok = (32'(q_cmd.slot) < CACHE_ENTRIES) && val_r[IW'(q_cmd.slot)];

  iccr_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(tag_r[vic_r]),
    .divisor(ipb), .busy(div_busy), .quot(div_q), .rem(div_rm)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      val_r <= '0;
      ref_r <= '0;
      dty_r <= '0;
      hand_r <= '0;
    end else begin
      case (st_r)
        S_IDLE: begin
          if (q_valid) begin
            cmd_r <= q_cmd;
            idx_r <= '0;
            cnt_r <= '0;
            case (iccr_pkg::op_t'(q_cmd.opcode))
              iccr_pkg::OP_GET: begin
                res_r <= '0;
                st_r <= S_SEARCH;
              end
              iccr_pkg::OP_INSERT: begin
                res_r <= '0;
                st_r <= S_SWEEP;
              end
              iccr_pkg::OP_DIRTY: begin
                res_r <= {dirty_ok, q_cmd.slot, {RestW{1'b0}}};
                if (dirty_ok) begin
                  dty_r[IW'(q_cmd.slot)] <= 1'b1;
                  ref_r[IW'(q_cmd.slot)] <= 1'b1;
                end
                st_r <= S_OUT;
              end
              default: begin
                res_r <= '0;
                st_r <= S_OUT;
              end
            endcase
          end
        end
        S_SEARCH: begin
          if (val_r[idx_r] && tag_r[idx_r] == cmd_r.ino_num) begin
            ref_r[idx_r] <= 1'b1;
            res_r.hit <= 1'b1;
            res_r.slot_out <= iccr_pkg::SlotW'(idx_r);
            st_r <= S_OUT;
          end else if (32'(idx_r) == CACHE_ENTRIES - 1) begin
            res_r.fill_needed <= 1'b1;
            st_r <= S_SWEEP;
          end else begin
            idx_r <= idx_inc;
          end
        end
        S_SWEEP: begin
          if (32'(cnt_r) == CACHE_ENTRIES || !val_r[hand_r] || !ref_r[hand_r]) begin
            vic_r <= hand_r;
            hand_r <= hand_inc;
            st_r <= S_INSTALL;
          end else begin
            ref_r[hand_r] <= 1'b0;
            hand_r <= hand_inc;
            cnt_r <= cnt_r + CW'(1);
          end
        end
        S_INSTALL: begin
          res_r.slot_out <= iccr_pkg::SlotW'(vic_r);
          if (val_r[vic_r] && dty_r[vic_r]) begin
            res_r.writeback_valid <= 1'b1;
            res_r.writeback_inode <= tag_r[vic_r];
            st_r <= S_DIV;
          end else begin
            st_r <= S_OUT;
          end
          val_r[vic_r] <= 1'b1;
          ref_r[vic_r] <= 1'b1;
          dty_r[vic_r] <= 1'b0;
          tag_r[vic_r] <= cmd_r.ino_num;
        end
        S_DIV: begin
          if (!div_busy) begin
            res_r.writeback_block <= div_q;
            res_r.writeback_offset <= div_rm[7:0];
            st_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (res_ready) st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  `ICCR_ASSERT_IMP(a_fill_miss, clk, rst_n, res_valid && res.fill_needed, !res.hit)
  `ICCR_ASSERT_IMP(a_wb_nohit, clk, rst_n, res_valid && res.writeback_valid, !res.hit)
  `ICCR_ASSERT_NEXT(a_install_valid, clk, rst_n, st_r == S_INSTALL, val_r[vic_r] && ref_r[vic_r])
endmodule

[sv/inode_cache_clock_replacement.sv]
// Top level of the inode cache clock replacement controller.
// Depends on iccr_pkg, iccr_front, iccr_back and the assertion macro header.
// Handles one word at a time: after dispatch a get searches the tags in turn,
// a miss or insert runs the clock sweep and then the install step, and a dirty
// victim then waits on the bit-serial divider; a mark_dirty or no-operation
// needs the dispatch step only. Each result then holds in the output state
// until accepted. A two-word queue accepts input while the back end works.
`include "inode_cache_clock_replacement_assert.svh"
module inode_cache_clock_replacement #(
  parameter int CACHE_ENTRIES = iccr_pkg::CacheEntriesDef
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [8:0] cfg_wdata,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [39:0] in_tdata,   // opcode[1:0], ino_num[33:2], slot[37:34]
  output logic out_tvalid,
  input  logic out_tready,
  output logic [79:0] out_tdata   // hit, slot_out, fill_needed, writeback_valid,
                                  // writeback_inode, writeback_block, writeback_offset
);
  logic [iccr_pkg::IpbW-1:0] ipb_r;
  iccr_pkg::cmd_t in_cmd, q_cmd;
  iccr_pkg::res_t res;
  logic q_valid, q_ready;

  assign in_cmd.opcode = in_tdata[1:0];
  assign in_cmd.ino_num = in_tdata[33:2];
  assign in_cmd.slot = in_tdata[37:34];

  always_ff @(posedge clk) begin
    if (!rst_n) ipb_r <= iccr_pkg::IpbReset;
    else if (cfg_we) ipb_r <= cfg_wdata;
  end

  iccr_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .in_cmd(in_cmd), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
  );

  iccr_back #(.CACHE_ENTRIES(CACHE_ENTRIES)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
    .ipb(ipb_r), .res_valid(out_tvalid), .res_ready(out_tready), .res(res)
  );

  assign out_tdata = {1'b0, res.writeback_offset, res.writeback_block,
                      res.writeback_inode, res.writeback_valid, res.fill_needed,
                      res.slot_out, res.hit};

  `ICCR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
endmodule

[tb/tb_top.sv]
// Testbench for the inode cache clock replacement controller: drives gets,
// inserts, mark_dirty and no-operation words, predicts each result and checks it in order.
// Depends on iccr_pkg and the inode_cache_clock_replacement RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Entries = 16;

  class inode_scoreboard;
    bit vld[Entries];
    bit refd[Entries];
    bit dty[Entries];
    logic [31:0] tag[Entries];
    int unsigned hand;
    logic [8:0] ipb;
    iccr_pkg::res_t pending[$];
    int mismatches;

    function new();
      for (int i = 0; i < Entries; i++) begin
        vld[i] = 0; refd[i] = 0; dty[i] = 0; tag[i] = '0;
      end
      hand = 0;
      ipb = iccr_pkg::IpbReset;
      mismatches = 0;
    endfunction

    function int unsigned choose_victim();
      int unsigned h;
      for (int n = 0; n < Entries; n++) begin
        h = hand;
        hand = (h + 1) % Entries;
        if (!vld[h] || !refd[h]) return h;
        refd[h] = 0;
      end
      h = hand;
      hand = (h + 1) % Entries;
      return h;
    endfunction

    function void install_inode(logic [31:0] num, ref iccr_pkg::res_t r);
      int unsigned v;
      logic [31:0] d;
      v = choose_victim();
      if (vld[v] && dty[v]) begin
        d = (ipb == 0) ? 32'd1 : {23'd0, ipb};
        r.writeback_valid = 1;
        r.writeback_inode = tag[v];
        r.writeback_block = tag[v] / d;
        r.writeback_offset = 8'((tag[v] % d) & 32'hFF);
      end
      vld[v] = 1; refd[v] = 1; dty[v] = 0; tag[v] = num;
      r.slot_out = 4'(v);
    endfunction

    function void note_word(iccr_pkg::cmd_t c);
      iccr_pkg::res_t r;
      bit found;
      r = '0;
      found = 0;
      case (iccr_pkg::op_t'(c.opcode))
        iccr_pkg::OP_GET: begin
          for (int i = 0; i < Entries && !found; i++)
            if (vld[i] && tag[i] == c.ino_num) begin
              refd[i] = 1; r.hit = 1; r.slot_out = 4'(i); found = 1;
            end
          if (!found) begin
            install_inode(c.ino_num, r);
            r.fill_needed = 1;
          end
        end
        iccr_pkg::OP_INSERT: install_inode(c.ino_num, r);
        iccr_pkg::OP_DIRTY: begin
          r.slot_out = c.slot;
          if (vld[c.slot]) begin
            dty[c.slot] = 1; refd[c.slot] = 1; r.hit = 1;
          end
        end
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    function void check_word(iccr_pkg::res_t got);
      iccr_pkg::res_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: hit %b/%b slot %0d/%0d fill %b/%b wb %b/%b",
                    " ino %h/%h blk %h/%h off %h/%h"},
                   exp_r.hit, got.hit, exp_r.slot_out, got.slot_out,
                   exp_r.fill_needed, got.fill_needed, exp_r.writeback_valid,
                   got.writeback_valid, exp_r.writeback_inode, got.writeback_inode,
                   exp_r.writeback_block, got.writeback_block,
                   exp_r.writeback_offset, got.writeback_offset);
      end
    endfunction
  endclass

  function automatic iccr_pkg::res_t unpack_res(logic [79:0] d);
    iccr_pkg::res_t r;
    r.hit = d[0];
    r.slot_out = d[4:1];
    r.fill_needed = d[5];
    r.writeback_valid = d[6];
    r.writeback_inode = d[38:7];
    r.writeback_block = d[70:39];
    r.writeback_offset = d[78:71];
    return r;
  endfunction

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [8:0] cfg_wdata = '0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [39:0] in_tdata = '0;   // opcode[1:0], ino_num[33:2], slot[37:34]
  logic out_tvalid;
  logic out_tready = 0;
  logic [79:0] out_tdata;       // hit, slot_out, fill, wb_valid, inode, block, offset

  inode_scoreboard sb;
  int unsigned idle_pct = 31;
  int unsigned cycles = 0;
  logic [31:0] recent[$];

  inode_cache_clock_replacement uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_word(unpack_res(out_tdata));
    out_tready <= ($urandom_range(99) >= idle_pct);
  end

  task automatic send_word(logic [1:0] op, logic [31:0] num, logic [3:0] sl);
    iccr_pkg::cmd_t c;
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    c.opcode = op; c.ino_num = num; c.slot = sl;
    in_tvalid <= 1;
    in_tdata <= {2'b00, c.slot, c.ino_num, c.opcode};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_word(c);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_ipb(logic [8:0] v);
    drain();
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.ipb = v;
  endtask

  task automatic random_words(int n);
    logic [31:0] num;
    int unsigned k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      num = $urandom;
      if (recent.size() != 0 && $urandom_range(1))
        num = recent[$urandom_range(recent.size() - 1)];
      else begin
        if ($urandom_range(3) == 0) num = $urandom_range(40);
        recent.push_back(num);
        if (recent.size() > 24) void'(recent.pop_front());
      end
      if (k < 50) send_word(iccr_pkg::OP_GET, num, 4'($urandom));
      else if (k < 65) send_word(iccr_pkg::OP_INSERT, num, 4'($urandom));
      else if (k < 95) send_word(iccr_pkg::OP_DIRTY, $urandom, 4'($urandom));
      else send_word(iccr_pkg::OP_NOP, $urandom, 4'($urandom));
    end
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_word(iccr_pkg::OP_DIRTY, 32'hFFFFFFFF, 4'd15);
    send_word(iccr_pkg::OP_NOP, 32'hFFFFFFFF, 4'd15);
    send_word(iccr_pkg::OP_GET, 32'd0, 4'd0);
    send_word(iccr_pkg::OP_GET, 32'hFFFFFFFF, 4'd0);
    send_word(iccr_pkg::OP_GET, 32'd0, 4'd0);
    send_word(iccr_pkg::OP_INSERT, 32'd0, 4'd0);
    send_word(iccr_pkg::OP_GET, 32'd0, 4'd0);
    send_word(iccr_pkg::OP_DIRTY, 32'd0, 4'd0);
    send_word(iccr_pkg::OP_DIRTY, 32'd0, 4'd1);
    send_word(iccr_pkg::OP_DIRTY, 32'd0, 4'd2);
    for (int i = 0; i < 14; i++) send_word(iccr_pkg::OP_INSERT, 32'hFFFFFF00 + i, 4'd0);
    send_word(iccr_pkg::OP_GET, 32'h12345678, 4'd0);
    write_ipb(9'd0);
    random_words(150);
    write_ipb(9'd511);
    random_words(150);
    write_ipb(9'd1);
    idle_pct = 0;
    random_words(250);
    idle_pct = 31;
    write_ipb(9'd256);
    random_words(250);
    write_ipb(9'($urandom_range(2, 255)));
    random_words(300);
    write_ipb(9'd8);
    random_words(300);
    drain();
    if (sb.mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule

[sim.f]
+incdir+sv
sv/iccr_pkg.sv
sv/iccr_front.sv
sv/iccr_div.sv
sv/iccr_back.sv
sv/inode_cache_clock_replacement.sv
tb/tb_top.sv
